// File: rtl/bds_pkg.sv
// shared types, constants and sample format helpers for the 2x2 box downsampler
`timescale 1ns / 1ps
`default_nettype none
package bds_pkg;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_MAX_BANDS = 4;
    localparam int NUM_PORTS     = 4;

    localparam int SAMPLE_W   = 32;
    localparam int SUM_W      = 34;
    localparam int WIDTH_W    = 13;
    localparam int HEIGHT_W   = 16;
    localparam int BAND_W     = 3;
    localparam int FMT_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BANDS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd3;

    localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 13'd256;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 16'd256;
    localparam logic [BAND_W-1:0]   RST_BANDS  = 3'd1;

    localparam logic [FMT_W-1:0] FMT_U8  = 3'd0;
    localparam logic [FMT_W-1:0] FMT_S8  = 3'd1;
    localparam logic [FMT_W-1:0] FMT_U16 = 3'd2;
    localparam logic [FMT_W-1:0] FMT_S16 = 3'd3;
    localparam logic [FMT_W-1:0] FMT_U32 = 3'd4;
    localparam logic [FMT_W-1:0] FMT_S32 = 3'd5;
    localparam logic [FMT_W-1:0] FMT_LAB = 3'd6;

    localparam logic [1:0] BAND_L = 2'd0;
    localparam logic [1:0] BAND_A = 2'd1;
    localparam logic [1:0] BAND_B = 2'd2;

    typedef struct packed {
        logic             hold_we;
        logic             odd_col;
        logic             ram_we;
        logic             ram_re;
        logic             result;
        logic             upper_from_ram;
        logic             end_of_row;
        logic             end_of_image;
        logic [FMT_W-1:0] fmt;
        logic [BAND_W-1:0] band_limit;
    } actl_t;

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    function automatic logic signed [SUM_W-1:0] widen(
        input logic [SAMPLE_W-1:0] raw,
        input logic [FMT_W-1:0]    fmt,
        input logic [1:0]          band
    );
        logic signed [SUM_W-1:0] v;
        case (fmt)
            FMT_S8:  v = {{26{raw[7]}}, raw[7:0]};
            FMT_U16: v = {18'b0, raw[15:0]};
            FMT_S16: v = {{18{raw[15]}}, raw[15:0]};
            FMT_U32: v = {2'b0, raw};
            FMT_S32: v = {{2{raw[31]}}, raw};
            FMT_LAB:
            begin
                if (band == BAND_L)
                begin
                    v = {26'b0, raw[7:0]};
                end
                else if (band == BAND_A || band == BAND_B)
                begin
                    v = {{26{raw[7]}}, raw[7:0]};
                end
                else
                begin
                    v = '0;
                end
            end
            default: v = {26'b0, raw[7:0]};
        endcase
        return v;
    endfunction

    function automatic logic [SAMPLE_W-1:0] fmt_mask(input logic [FMT_W-1:0] fmt);
        logic [SAMPLE_W-1:0] m;
        case (fmt)
            FMT_U16, FMT_S16: m = 32'h0000_FFFF;
            FMT_U32, FMT_S32: m = 32'hFFFF_FFFF;
            default:          m = 32'h0000_00FF;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

// File: rtl/bds_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module bds_ram #(
    parameter int WIDTH = 136,
    parameter int DEPTH = 2048
) (
    input  wire logic                                clk,
    input  wire logic                                we,
    input  wire logic [bds_pkg::addr_w(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]                    wdata,
    input  wire logic                                re,
    input  wire logic [bds_pkg::addr_w(DEPTH)-1:0]   raddr,
    output logic      [WIDTH-1:0]                    rdata
);
    import bds_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/bds_ctrl.sv
// configuration registers, column and row counters and per-pixel decode
`timescale 1ns / 1ps
`default_nettype none
module bds_ctrl #(
    parameter int MAX_WIDTH = bds_pkg::DEF_MAX_WIDTH,
    parameter int MAX_BANDS = bds_pkg::DEF_MAX_BANDS
) (
    input  wire logic                                               clk,
    input  wire logic                                               rst_n,
    input  wire logic                                               cfg_we,
    input  wire logic [bds_pkg::CFG_IDX_W-1:0]                      cfg_index,
    input  wire logic [bds_pkg::CFG_DATA_W-1:0]                     cfg_data,
    input  wire logic                                               fire,
    output bds_pkg::actl_t                                          actl,
    output logic [bds_pkg::addr_w((MAX_WIDTH + 1) / 2)-1:0]         addr
);
    import bds_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int AW    = addr_w((MAX_WIDTH + 1) / 2);
    localparam int CMP_W = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;
    localparam logic [CMP_W-1:0]  MAXW_C  = CMP_W'(MAX_WIDTH);
    localparam logic [BAND_W-1:0] MAXB_C  = BAND_W'(MAX_BANDS);
    localparam logic [BAND_W-1:0] LAB_NB  = (MAX_BANDS < 3) ? BAND_W'(MAX_BANDS) : 3'd3;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [BAND_W-1:0]   bands_reg;
    logic [FMT_W-1:0]    fmt_reg;
    logic [CW-1:0]       col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;

    logic [CW:0]         col_inc;
    logic [CW:0]         col_half;
    logic [HEIGHT_W:0]   row_inc;
    logic                last_col, last_row, pair_ok, odd_row;
    logic [FMT_W-1:0]    fmt_eff;
    logic [BAND_W-1:0]   nb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            bands_reg  <= RST_BANDS;
            fmt_reg    <= FMT_U8;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                CFG_BANDS:  bands_reg  <= cfg_data[BAND_W-1:0];
                CFG_FORMAT: fmt_reg    <= cfg_data[FMT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        col_inc  = {1'b0, col_reg} + 1'b1;
        row_inc  = {1'b0, row_reg} + 1'b1;
        col_half = {1'b0, col_reg} >> 1;
        last_col = (width_reg == '0) || (CMP_W'(col_inc) >= CMP_W'(width_reg))
                   || (CMP_W'(col_inc) >= MAXW_C);
        last_row = (height_reg == '0) || (row_inc >= {1'b0, height_reg});
        pair_ok  = col_reg[0] || last_col;
        odd_row  = row_reg[0];

        fmt_eff = (fmt_reg > FMT_LAB) ? FMT_U8 : fmt_reg;
        if (bands_reg == '0)
        begin
            nb = 3'd1;
        end
        else if (bands_reg > MAXB_C)
        begin
            nb = MAXB_C;
        end
        else
        begin
            nb = bands_reg;
        end
        if (fmt_eff == FMT_LAB)
        begin
            nb = LAB_NB;
        end

        actl.hold_we        = !pair_ok;
        actl.odd_col        = col_reg[0];
        actl.ram_we         = pair_ok && !odd_row && !last_row;
        actl.ram_re         = pair_ok && odd_row;
        actl.result         = pair_ok && (odd_row || last_row);
        actl.upper_from_ram = odd_row;
        actl.end_of_row     = last_col;
        actl.end_of_image   = last_col && last_row;
        actl.fmt            = fmt_eff;
        actl.band_limit     = nb;

        addr = col_half[AW-1:0];

        col_next = col_reg;
        row_next = row_reg;
        if (fire)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_inc[HEIGHT_W-1:0];
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/bds_lane.sv
// one band lane: widening, horizontal pair sum, left hold and block average
`timescale 1ns / 1ps
`default_nettype none
module bds_lane #(
    parameter int LANE = 0
) (
    input  wire logic                                clk,
    input  wire logic                                fire,
    input  wire bds_pkg::actl_t                      actl,
    input  wire logic [bds_pkg::SAMPLE_W-1:0]        sample,
    output logic signed [bds_pkg::SUM_W-1:0]         pair,
    input  wire logic                                b_load,
    input  wire bds_pkg::actl_t                      b_actl,
    input  wire logic [bds_pkg::SUM_W-1:0]           ram_upper,
    output logic [bds_pkg::SAMPLE_W-1:0]             result
);
    import bds_pkg::*;

    localparam logic [1:0]        BAND_ID = 2'(LANE);
    localparam logic [BAND_W-1:0] LANE_C  = BAND_W'(LANE);

    logic [SAMPLE_W-1:0]     hold_reg;
    logic signed [SUM_W-1:0] pair_b_reg;
    logic signed [SUM_W-1:0] cur, left, upper;
    logic signed [SUM_W:0]   total;

    always_comb
    begin
        cur  = widen(sample, actl.fmt, BAND_ID);
        left = widen(hold_reg, actl.fmt, BAND_ID);
        pair = actl.odd_col ? left + cur : cur + cur;
    end

    always_ff @(posedge clk)
    begin
        if (fire && actl.hold_we)
        begin
            hold_reg <= sample;
        end
        if (b_load)
        begin
            pair_b_reg <= pair;
        end
    end

    // floor divide by four is an arithmetic shift of the block sum
    always_comb
    begin
        upper  = b_actl.upper_from_ram ? signed'(ram_upper) : pair_b_reg;
        total  = {upper[SUM_W-1], upper} + {pair_b_reg[SUM_W-1], pair_b_reg};
        result = (LANE_C < b_actl.band_limit) ? (total[SUM_W-1:2] & fmt_mask(b_actl.fmt)) : '0;
    end

endmodule
`default_nettype wire

// File: rtl/box_downsample_2x2.sv
// top level of the 2x2 box downsampler: lanes, line store and output merge
// a block's last pixel loads the block registers, and its result then moves to the output register
// throughput: one input pixel per clock unless stalled; the line store takes one access per pixel
// even rows but the last write pair sums, odd rows read them, never both in one cycle
// reset clears the counters, the pipeline valids and loads the default configuration
// the line store and the left-pixel holds are not cleared; they are written before being read
`timescale 1ns / 1ps
`default_nettype none
module box_downsample_2x2 #(
    parameter int MAX_WIDTH = bds_pkg::DEF_MAX_WIDTH,
    parameter int MAX_BANDS = bds_pkg::DEF_MAX_BANDS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [bds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bds_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [bds_pkg::SAMPLE_W-1:0]       sample0,
    input  wire logic [bds_pkg::SAMPLE_W-1:0]       sample1,
    input  wire logic [bds_pkg::SAMPLE_W-1:0]       sample2,
    input  wire logic [bds_pkg::SAMPLE_W-1:0]       sample3,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [bds_pkg::SAMPLE_W-1:0]            out_sample0,
    output logic [bds_pkg::SAMPLE_W-1:0]            out_sample1,
    output logic [bds_pkg::SAMPLE_W-1:0]            out_sample2,
    output logic [bds_pkg::SAMPLE_W-1:0]            out_sample3,
    output logic                                    end_of_row,
    output logic                                    end_of_image
);
    import bds_pkg::*;

    localparam int RAM_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW        = addr_w(RAM_DEPTH);
    localparam int RAM_W     = MAX_BANDS * SUM_W;

    actl_t               actl;
    actl_t               b_actl_reg;
    logic                b_valid_reg, b_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_sample_reg [NUM_PORTS];
    logic                eor_reg, eoi_reg;

    logic                fire, adv_out, b_load;
    logic [AW-1:0]       addr;
    logic [RAM_W-1:0]    ram_wdata, ram_rdata;
    logic [SAMPLE_W-1:0] in_samples [NUM_PORTS];
    logic [SAMPLE_W-1:0] lane_res [NUM_PORTS];

    assign in_samples[0] = sample0;
    assign in_samples[1] = sample1;
    assign in_samples[2] = sample2;
    assign in_samples[3] = sample3;

    assign adv_out  = !out_valid_reg || !out_stall;
    assign in_stall = b_valid_reg && !adv_out;
    assign fire     = in_valid && !in_stall;
    assign b_load   = fire && actl.result;

    bds_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BANDS (MAX_BANDS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .actl      (actl),
        .addr      (addr)
    );

    bds_ram #(
        .WIDTH (RAM_W),
        .DEPTH (RAM_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (fire && actl.ram_we),
        .waddr (addr),
        .wdata (ram_wdata),
        .re    (fire && actl.ram_re),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    genvar b;
    generate
        for (b = 0; b < NUM_PORTS; b++)
        begin : g_lane
            if (b < MAX_BANDS)
            begin : g_used
                logic signed [SUM_W-1:0] pair;

                bds_lane #(
                    .LANE (b)
                ) u_lane (
                    .clk       (clk),
                    .fire      (fire),
                    .actl      (actl),
                    .sample    (in_samples[b]),
                    .pair      (pair),
                    .b_load    (b_load),
                    .b_actl    (b_actl_reg),
                    .ram_upper (ram_rdata[b*SUM_W +: SUM_W]),
                    .result    (lane_res[b])
                );

                assign ram_wdata[b*SUM_W +: SUM_W] = pair;
            end
            else
            begin : g_unused
                assign lane_res[b] = '0;
            end
        end
    endgenerate

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (fire)
        begin
            b_valid_next = actl.result;
        end
        else if (adv_out)
        begin
            b_valid_next = 1'b0;
        end
        out_valid_next = adv_out ? b_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // register the block controls and merge the lane results into the output register
    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_actl_reg <= actl;
        end
        if (adv_out && b_valid_reg)
        begin
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                out_sample_reg[i] <= lane_res[i];
            end
            eor_reg <= b_actl_reg.end_of_row;
            eoi_reg <= b_actl_reg.end_of_image;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_sample0  = out_sample_reg[0];
    assign out_sample1  = out_sample_reg[1];
    assign out_sample2  = out_sample_reg[2];
    assign out_sample3  = out_sample_reg[3];
    assign end_of_row   = eor_reg;
    assign end_of_image = eoi_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (b_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled while the pipeline has room");

    a_store_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !(actl.ram_we && actl.ram_re))
        else $error("line store written and read by one pixel");

    a_eoi_has_eor: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_image) |-> end_of_row)
        else $error("end of image without end of row");

    a_held_block_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !adv_out) |=> (b_valid_reg && $stable(b_actl_reg)))
        else $error("pending block lost while output stalled");

endmodule
`default_nettype wire
